/* src/ufar_pkg.sv */
// Package for the UDP flow aggregation and ranking block.
// Holds the flow entry type, the controller states and the voice port filter.
// No dependencies.
`default_nettype none

package ufar_pkg;

    localparam int MAX_FLOWS_DEF = 8;
    localparam int LIMIT_W       = 4;
    localparam int IN_DATA_W     = 136;
    localparam int OUT_DATA_W    = 136;
    localparam int NUM_RANGES    = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

    localparam logic [15:0] VOICE_LO [NUM_RANGES] = '{16'd50000, 16'd1400, 16'd3478,
                                                       16'd5349, 16'd19294};
    localparam logic [15:0] VOICE_HI [NUM_RANGES] = '{16'd50099, 16'd1400, 16'd3481,
                                                       16'd5349, 16'd19344};

    typedef struct packed {
        logic [31:0] dst_addr;
        logic [15:0] dst_port;
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [31:0] packets;
        logic        answered;
    } flow_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CK,
        ST_APPEND,
        ST_SORT_RD,
        ST_SORT_CK,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    function automatic logic port_is_voice(input logic [15:0] port);
        logic hit;
        hit = 1'b0;
        for (int r = 0; r < NUM_RANGES; r++)
        begin
            if (port >= VOICE_LO[r] && port <= VOICE_HI[r])
            begin
                hit = 1'b1;
            end
        end
        return hit && (port != 16'd0);
    endfunction

endpackage

`default_nettype wire

/* src/udp_flow_aggregate_rank.sv */
// Top level of the UDP voice flow aggregator with ranked flush.
// Flow table in one synchronous memory; depends on ufar_pkg.
//
// Channel | Direction | Transfer contents
// s_*     | in        | tuser: req_type; tdata: record fields
// m_*     | out       | tuser: entry_valid; tdata: ranked flow; tlast: end of run
// cfg_*   | in        | flow_limit write
//
// A record is accepted in the idle state; each stored flow examined then takes a
// memory read state and a compare state, and a new flow is written in the append state.
// A flush finds every rank by a full pass over the table through the single read port.
// Reset clears the flow count and the limit goes to 8; table contents are not cleared.
// A stalled output holds the controller only when the next result is ready.
`default_nettype none

module udp_flow_aggregate_rank #(
    parameter int MAX_FLOWS = ufar_pkg::MAX_FLOWS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // Lowest bit up: is_udp, dst_addr, dst_is_private, dst_port_in, src_addr,
    // src_port_in, packet_count, unreplied, zero fill.
    input  wire logic [ufar_pkg::IN_DATA_W-1:0]  s_tdata,
    // req_type.
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // Lowest bit up: rank, flow_dst_addr, flow_dst_port, flow_src_addr,
    // flow_src_port, packet_total, answered, flow_total.
    output logic [ufar_pkg::OUT_DATA_W-1:0]      m_tdata,
    // entry_valid.
    output logic                                 m_tuser,
    output logic                                 m_tlast,
    input  wire logic                            cfg_we,
    input  wire logic [ufar_pkg::LIMIT_W-1:0]    cfg_data
);
    import ufar_pkg::*;

    localparam int IDX_W = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
    localparam int CNT_W = $clog2(MAX_FLOWS + 1);
    localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_FLOWS);

    flow_entry_t mem [MAX_FLOWS];
    flow_entry_t rd_data_reg;
    logic        wr_en;
    logic [IDX_W-1:0] wr_addr;
    flow_entry_t wr_data;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] rank_reg, rank_next;
    logic [MAX_FLOWS-1:0] done_reg, done_next;
    logic [LIMIT_W-1:0] limit_reg;
    flow_entry_t in_reg, in_next;
    flow_entry_t best_reg, best_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic have_best_reg, have_best_next;
    logic out_vld_reg, out_vld_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic out_user_reg, out_user_next;
    logic out_last_reg, out_last_next;

    logic [LIM_W-1:0] eff_limit;
    logic        room;
    logic        hit;
    logic        more;
    logic        out_free;
    logic        in_keep;
    flow_entry_t in_rec;
    logic [32:0] sum;
    logic [31:0] sat_sum;

    assign eff_limit = (LIM_W'(limit_reg) > MAX_LIM) ? MAX_LIM : LIM_W'(limit_reg);
    assign room      = LIM_W'(used_reg) < eff_limit;
    assign hit       = (rd_data_reg.dst_addr == in_reg.dst_addr) &&
                       (rd_data_reg.dst_port == in_reg.dst_port) &&
                       (rd_data_reg.src_addr == in_reg.src_addr) &&
                       (rd_data_reg.src_port == in_reg.src_port);
    assign more      = (CNT_W'(cur_reg) + CNT_W'(1)) < used_reg;
    assign out_free  = !out_vld_reg || m_tready;
    assign sum       = {1'b0, rd_data_reg.packets} + {1'b0, in_reg.packets};
    assign sat_sum   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

    always_comb
    begin
        in_rec.dst_addr = s_tdata[32:1];
        in_rec.dst_port = s_tdata[49:34];
        in_rec.src_addr = s_tdata[81:50];
        in_rec.src_port = s_tdata[97:82];
        in_rec.packets  = s_tdata[129:98];
        in_rec.answered = !s_tdata[130];
        in_keep = s_tdata[0] && !s_tdata[33] && port_is_voice(s_tdata[49:34]);
    end

    // Next state and register updates.
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        used_next      = used_reg;
        rank_next      = rank_reg;
        done_next      = done_reg;
        in_next        = in_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        have_best_next = have_best_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    in_next  = in_rec;
                    cur_next = '0;
                    if (s_tuser)
                    begin
                        rank_next      = '0;
                        have_best_next = 1'b0;
                        state_next     = (used_reg == '0) ? ST_EMPTY : ST_SORT_RD;
                    end
                    else if (in_keep)
                    begin
                        state_next = (used_reg == '0) ? ST_APPEND : ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CK;
            end
            ST_SCAN_CK:
            begin
                if (hit)
                begin
                    state_next = ST_IDLE;
                end
                else if (more)
                begin
                    cur_next   = cur_reg + IDX_W'(1);
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                if (room)
                begin
                    used_next = used_reg + CNT_W'(1);
                end
                state_next = ST_IDLE;
            end
            ST_SORT_RD:
            begin
                state_next = ST_SORT_CK;
            end
            ST_SORT_CK:
            begin
                // Strict compare keeps the lowest index among equal counts.
                if (!done_reg[cur_reg] &&
                    (!have_best_reg || rd_data_reg.packets > best_reg.packets))
                begin
                    best_next      = rd_data_reg;
                    best_idx_next  = cur_reg;
                    have_best_next = 1'b1;
                end
                if (more)
                begin
                    cur_next   = cur_reg + IDX_W'(1);
                    state_next = ST_SORT_RD;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_user_next = 1'b1;
                    out_data_next = {LIMIT_W'(used_reg), best_reg.answered, best_reg.packets,
                                     best_reg.src_port, best_reg.src_addr,
                                     best_reg.dst_port, best_reg.dst_addr, 3'(rank_reg)};
                    out_last_next = (rank_reg + CNT_W'(1)) == used_reg;
                    done_next[best_idx_reg] = 1'b1;
                    rank_next      = rank_reg + CNT_W'(1);
                    have_best_next = 1'b0;
                    cur_next       = '0;
                    if ((rank_reg + CNT_W'(1)) == used_reg)
                    begin
                        used_next  = '0;
                        done_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SORT_RD;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_user_next = 1'b0;
                    out_data_next = '0;
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake and memory write strobes.
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        wr_en    = 1'b0;
        wr_addr  = cur_reg;
        wr_data  = in_reg;
        case (state_reg)
            ST_SCAN_CK:
            begin
                if (hit)
                begin
                    wr_en            = 1'b1;
                    wr_data          = rd_data_reg;
                    wr_data.packets  = sat_sum;
                    wr_data.answered = rd_data_reg.answered | in_reg.answered;
                end
            end
            ST_APPEND:
            begin
                wr_en   = room;
                wr_addr = used_reg[IDX_W-1:0];
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[cur_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            done_reg      <= '0;
            have_best_reg <= 1'b0;
            out_vld_reg   <= 1'b0;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            done_reg      <= done_next;
            have_best_reg <= have_best_next;
            out_vld_reg   <= out_vld_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        rank_reg     <= rank_next;
        in_reg       <= in_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(MAX_FLOWS))
        else $error("flow count exceeds table depth");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_SCAN_CK || state_reg == ST_APPEND))
        else $error("table write outside record update");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("empty-table result without end of run");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser && m_tlast && !$past(m_tvalid && m_tuser && m_tlast))
        |-> (used_reg == '0))
        else $error("table not cleared after final ranked transfer");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for udp_flow_aggregate_rank.
// Drives records and flushes over the stream input and checks ranked flows
// against an internal flow table predictor; depends on ufar_pkg and the RTL.
`default_nettype none

module testbench;
    import ufar_pkg::*;

    localparam int DEPTH = 8;
    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    typedef struct packed {
        logic        req;
        logic        is_udp;
        logic [31:0] daddr;
        logic        priv;
        logic [15:0] dport;
        logic [31:0] saddr;
        logic [15:0] sport;
        logic [31:0] pkts;
        logic        unreplied;
    } record_t;

    typedef struct packed {
        logic        entry_valid;
        logic [2:0]  rank;
        logic [31:0] daddr;
        logic [15:0] dport;
        logic [31:0] saddr;
        logic [15:0] sport;
        logic [31:0] total;
        logic        answered;
        logic [3:0]  flow_total;
        logic        last;
    } ranked_flow_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;
    logic cfg_we;
    logic [LIMIT_W-1:0] cfg_data;

    udp_flow_aggregate_rank DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    // Predicted flow table
    flow_entry_t flows [DEPTH];
    int unsigned flow_count;
    logic [3:0] limit_shadow;

    record_t pending_records[$];
    ranked_flow_t expected_flows[$];
    int mismatches;
    int idle_cycles;
    int hold_off;
    int recv_gap;
    bit hold_req;
    bit hold_done;
    bit stim_done;
    bit finished;

    function automatic bit voice_port(logic [15:0] p);
        if (p == 16'd0)
            return 0;
        return (p >= 16'd50000 && p <= 16'd50099) || p == 16'd1400 ||
               (p >= 16'd3478 && p <= 16'd3481) || p == 16'd5349 ||
               (p >= 16'd19294 && p <= 16'd19344);
    endfunction

    task automatic predict_transfer(record_t r);
        ranked_flow_t o;
        int unsigned order [DEPTH];
        int unsigned t;
        int unsigned j;
        int unsigned lim;
        logic [32:0] sum;
        if (r.req == REQ_RECORD)
        begin
            if (!r.is_udp || r.priv || !voice_port(r.dport))
                return;
            for (int i = 0; i < flow_count; i++)
            begin
                if (flows[i].dst_addr == r.daddr && flows[i].dst_port == r.dport &&
                    flows[i].src_addr == r.saddr && flows[i].src_port == r.sport)
                begin
                    sum = {1'b0, flows[i].packets} + {1'b0, r.pkts};
                    flows[i].packets = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    flows[i].answered = flows[i].answered | ~r.unreplied;
                    return;
                end
            end
            lim = (limit_shadow > DEPTH) ? DEPTH : limit_shadow;
            if (flow_count < lim)
            begin
                flows[flow_count] = '{r.daddr, r.dport, r.saddr, r.sport, r.pkts, ~r.unreplied};
                flow_count++;
            end
            return;
        end
        if (flow_count == 0)
        begin
            o = '0;
            o.last = 1'b1;
            expected_flows.push_back(o);
            return;
        end
        for (int i = 0; i < flow_count; i++)
            order[i] = i;
        for (int i = 1; i < flow_count; i++)
        begin
            t = order[i];
            j = i;
            while (j > 0 && flows[order[j-1]].packets < flows[t].packets)
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = t;
        end
        for (int i = 0; i < flow_count; i++)
        begin
            o.entry_valid = 1'b1;
            o.rank = i[2:0];
            o.daddr = flows[order[i]].dst_addr;
            o.dport = flows[order[i]].dst_port;
            o.saddr = flows[order[i]].src_addr;
            o.sport = flows[order[i]].src_port;
            o.total = flows[order[i]].packets;
            o.answered = flows[order[i]].answered;
            o.flow_total = flow_count[3:0];
            o.last = (i + 1 == flow_count);
            expected_flows.push_back(o);
        end
        flow_count = 0;
    endtask

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    bit s_tready_seen;
    bit drive_enable;
    int accepted_records;

    // Sender: drive the head of the pending queue, with random gaps.
    int send_gap;
    always @(negedge clk)
    begin
        if (!s_tvalid || s_tready_seen)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_records.size() > 0 && drive_enable)
            begin
                s_tvalid <= 1'b1;
                s_tuser <= pending_records[0].req;
                s_tdata <= {5'd0, pending_records[0].unreplied, pending_records[0].pkts,
                            pending_records[0].sport, pending_records[0].saddr,
                            pending_records[0].dport, pending_records[0].priv,
                            pending_records[0].daddr, pending_records[0].is_udp};
                send_gap <= gap_length();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        s_tready_seen <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_transfer(pending_records.pop_front());
            accepted_records++;
        end
    end

    // Receiver: random gaps plus one long hold-off when requested.
    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_off <= 400;
            m_tready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            recv_gap <= gap_length();
        end
    end

    // Monitor
    ranked_flow_t got;
    ranked_flow_t want;
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got.entry_valid = m_tuser;
            {got.flow_total, got.answered, got.total, got.sport, got.saddr,
             got.dport, got.daddr, got.rank} = m_tdata;
            got.last = m_tlast;
            if (expected_flows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", got);
            end
            else
            begin
                want = expected_flows.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000 && !finished)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic record_t voice_record(bit from_pool, int pool_sel);
        record_t r;
        logic [15:0] ports [7];
        ports = '{16'd50000, 16'd50099, 16'd1400, 16'd3478, 16'd3481, 16'd5349, 16'd19344};
        r.req = REQ_RECORD;
        r.is_udp = 1'b1;
        r.priv = 1'b0;
        r.unreplied = 1'($urandom_range(0, 1));
        r.pkts = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 20);
        if (from_pool)
        begin
            r.daddr = 32'h0A00_0000 + 32'(pool_sel);
            r.saddr = 32'hC0A8_0000 + 32'(pool_sel % 3);
            r.dport = ports[pool_sel % 7];
            r.sport = 16'd4000 + 16'(pool_sel);
        end
        else
        begin
            r.daddr = $urandom;
            r.saddr = $urandom;
            r.dport = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                      16'd19294 + 16'($urandom_range(0, 50));
            r.sport = 16'($urandom);
        end
        return r;
    endfunction

    function automatic record_t flush_item();
        record_t r;
        r = $bits(record_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
        r.req = REQ_FLUSH;
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_records.size() > 0 || expected_flows.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_limit(logic [3:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        limit_shadow = v;
    endtask

    record_t r;
    logic [3:0] limits [6];
    initial
    begin
        limits = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5};
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
        m_tready = 1'b0; cfg_we = 1'b0; cfg_data = '0;
        drive_enable = 1'b1;
        limit_shadow = LIMIT_RESET;
        flow_count = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty flush, filters, saturation, ties, full table
        pending_records.push_back(flush_item());
        r = voice_record(1, 0); r.pkts = 32'hFFFF_FFF0; pending_records.push_back(r);
        r.pkts = 32'h100; r.unreplied = 1'b1; pending_records.push_back(r);
        r = voice_record(1, 1); r.is_udp = 1'b0; pending_records.push_back(r);
        r = voice_record(1, 1); r.priv = 1'b1; pending_records.push_back(r);
        r = voice_record(1, 1); r.dport = 16'd0; pending_records.push_back(r);
        r = voice_record(1, 1); r.dport = 16'd65535; pending_records.push_back(r);
        r = voice_record(1, 1); r.dport = 16'd49999; pending_records.push_back(r);
        for (int i = 1; i < 10; i++)
        begin
            r = voice_record(1, i); r.pkts = 32'd7; pending_records.push_back(r);
        end
        r = voice_record(0, 0); r.daddr = '1; r.saddr = '1; r.sport = '1;
        r.pkts = '1; pending_records.push_back(r);
        pending_records.push_back(flush_item());
        pending_records.push_back(flush_item());
        wait_drained();

        // Random phases through several limits, one with a long receiver hold-off
        for (int ph = 0; ph < 6; ph++)
        begin
            write_limit(limits[ph]);
            if (ph == 2)
                hold_req = 1'b1;
            for (int k = 0; k < 75; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    pending_records.push_back(flush_item());
                else if ($urandom_range(0, 9) < 8)
                    pending_records.push_back(voice_record(1, $urandom_range(0, 11)));
                else
                begin
                    r = $bits(record_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
                    r.req = REQ_RECORD;
                    pending_records.push_back(r);
                end
            end
            pending_records.push_back(flush_item());
            wait_drained();
        end

        finished = 1'b1;
        if (mismatches == 0 && expected_flows.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

`default_nettype wire

/* sim.f */
src/ufar_pkg.sv
src/udp_flow_aggregate_rank.sv
tb/testbench.sv
